FILE: rtl/pru_pkg.sv
package pru_pkg;

    // Default sizes of the line store and of the replication factor.
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_SCALE_DEF = 16;

    // Fixed field widths.
    localparam int ROW_WIDTH_W = 11;
    localparam int SCALE_W     = 5;
    localparam int PIXEL_W     = 24;
    localparam int KIND_W      = 2;
    localparam int CFG_DATA_W  = 11;

    // Configuration register indexes.
    localparam logic CFG_ROW_WIDTH = 1'b0;
    localparam logic CFG_SCALE     = 1'b1;

    // Input item actions.
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_PIXEL  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAD    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

    // One emission job handed from the control stage to the emitter.
    typedef struct packed {
        logic               rej;       // single rejected-pixel result
        logic               from_mem;  // pixel comes from the line store read data
        logic [1:0]         pad;       // zero pad bytes after the pixel copies
        logic [PIXEL_W-1:0] bgr;       // pixel when not taken from the line store
    } t_job;

endpackage

FILE: rtl/pru_line_store.sv
module pru_line_store #(
    parameter int DEPTH = pru_pkg::MAX_WIDTH_DEF,
    parameter int AW    = 10
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_addr,
    input  logic [pru_pkg::PIXEL_W-1:0] i_wdata,
    output logic [pru_pkg::PIXEL_W-1:0] o_rdata
);

    logic [pru_pkg::PIXEL_W-1:0] r_mem [DEPTH];
    logic [pru_pkg::PIXEL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // Read data is held until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rd_data;

endmodule

FILE: rtl/pru_ctrl.sv
module pru_ctrl #(
    parameter int MAX_WIDTH = pru_pkg::MAX_WIDTH_DEF,
    parameter int MAX_SCALE = pru_pkg::MAX_SCALE_DEF,
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int SW = $clog2(MAX_SCALE + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_index,
    input  logic [pru_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_action,
    input  logic [pru_pkg::PIXEL_W-1:0]    i_pixel,
    input  logic                           i_take,
    output logic                           o_job_valid,
    output pru_pkg::t_job                  o_job,
    output logic [SW-1:0]                  o_job_pix,
    output logic                           o_mem_we,
    output logic                           o_mem_re,
    output logic [AW-1:0]                  o_mem_addr,
    output logic [pru_pkg::PIXEL_W-1:0]    o_mem_wdata
);

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int RW  = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
    localparam int WCW = (WW > pru_pkg::ROW_WIDTH_W) ? WW : pru_pkg::ROW_WIDTH_W;
    localparam int SCW = (SW > pru_pkg::SCALE_W) ? SW : pru_pkg::SCALE_W;

    logic [pru_pkg::ROW_WIDTH_W-1:0] r_row_width;
    logic [pru_pkg::SCALE_W-1:0]     r_scale;
    logic [AW-1:0]                   r_col,        n_col;
    logic [AW-1:0]                   r_rcol,       n_rcol;
    logic [RW-1:0]                   r_rows,       n_rows;
    logic                            r_replaying,  n_replaying;
    logic                            r_job_valid,  n_job_valid;
    pru_pkg::t_job                   r_job,        n_job;
    logic [SW-1:0]                   r_job_pix,    n_job_pix;

    logic [WCW-1:0] w_raw;
    logic [SCW-1:0] s_raw;
    logic [WW-1:0]  eff_w;
    logic [SW-1:0]  eff_s;
    logic [1:0]     w_lo;
    logic [1:0]     s_lo;
    logic [3:0]     pad_prod;
    logic           accept;
    logic [AW-1:0]  cur_col;
    logic           row_end;
    logic [RW-1:0]  first_rows;

    // Effective width and scale: zero acts as one, large values saturate.
    always_comb begin
        w_raw = WCW'(r_row_width);
        s_raw = SCW'(r_scale);
        if (w_raw == '0) begin
            eff_w = WW'(1);
        end else if (w_raw > WCW'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(w_raw);
        end
        if (s_raw == '0) begin
            eff_s = SW'(1);
        end else if (s_raw > SCW'(MAX_SCALE)) begin
            eff_s = SW'(MAX_SCALE);
        end else begin
            eff_s = SW'(s_raw);
        end
    end

    // A row of width*scale*3 bytes needs (width*scale) mod 4 pad bytes.
    assign w_lo     = 2'(eff_w);
    assign s_lo     = 2'(eff_s);
    assign pad_prod = {2'b00, w_lo} * {2'b00, s_lo};

    assign o_ready    = !r_job_valid || i_take;
    assign accept     = i_valid && o_ready;
    assign cur_col    = r_replaying ? r_rcol : r_col;
    assign row_end    = WW'(cur_col) >= (eff_w - WW'(1));
    assign first_rows = RW'(eff_s - SW'(1));

    assign o_mem_we    = accept && (i_action == pru_pkg::ACT_PIXEL) && !r_replaying;
    assign o_mem_re    = accept && (i_action == pru_pkg::ACT_TICK) && r_replaying;
    assign o_mem_addr  = cur_col;
    assign o_mem_wdata = i_pixel;

    always_comb begin
        n_col       = r_col;
        n_rcol      = r_rcol;
        n_rows      = r_rows;
        n_replaying = r_replaying;
        n_job_valid = r_job_valid && !i_take;
        n_job       = r_job;
        n_job_pix   = r_job_pix;
        if (accept) begin
            n_job.rej      = 1'b0;
            n_job.from_mem = 1'b0;
            n_job.pad      = row_end ? pad_prod[1:0] : 2'b00;
            n_job.bgr      = i_pixel;
            n_job_pix      = eff_s;
            if (i_action == pru_pkg::ACT_PIXEL) begin
                n_job_valid = 1'b1;
                if (r_replaying) begin
                    n_job.rej = 1'b1;
                    n_job.pad = 2'b00;
                    n_job_pix = '0;
                end else if (row_end) begin
                    n_col       = '0;
                    n_rcol      = '0;
                    n_rows      = first_rows;
                    n_replaying = first_rows != '0;
                end else begin
                    n_col = r_col + AW'(1);
                end
            end else if (r_replaying) begin
                n_job_valid    = 1'b1;
                n_job.from_mem = 1'b1;
                if (row_end) begin
                    n_rcol      = '0;
                    n_rows      = r_rows - RW'(1);
                    n_replaying = r_rows != RW'(1);
                end else begin
                    n_rcol = r_rcol + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= pru_pkg::ROW_WIDTH_W'(1);
            r_scale     <= pru_pkg::SCALE_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pru_pkg::CFG_ROW_WIDTH: r_row_width <= i_cfg_data;
                pru_pkg::CFG_SCALE:     r_scale     <= i_cfg_data[pru_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_rcol      <= '0;
            r_rows      <= '0;
            r_replaying <= 1'b0;
            r_job_valid <= 1'b0;
        end else begin
            r_col       <= n_col;
            r_rcol      <= n_rcol;
            r_rows      <= n_rows;
            r_replaying <= n_replaying;
            r_job_valid <= n_job_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job     <= n_job;
        r_job_pix <= n_job_pix;
    end

    assign o_job_valid = r_job_valid;
    assign o_job       = r_job;
    assign o_job_pix   = r_job_pix;

`ifndef NO_ASSERTIONS
    a_replay_has_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_replaying |-> (r_rows != '0))
        else $error("replay active with no rows left");
    a_idle_replay_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_replaying |-> (r_rcol == '0))
        else $error("replay column not rewound outside replay");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_job_valid && !i_take) |=> ($stable(r_job) && r_job_valid))
        else $error("pending job changed before the emitter took it");
`endif

endmodule

FILE: rtl/pru_emit.sv
module pru_emit #(
    parameter int MAX_SCALE = pru_pkg::MAX_SCALE_DEF,
    localparam int SW = $clog2(MAX_SCALE + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_job_valid,
    input  pru_pkg::t_job               i_job,
    input  logic [SW-1:0]               i_job_pix,
    input  logic [pru_pkg::PIXEL_W-1:0] i_mem_data,
    output logic                        o_take,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [pru_pkg::KIND_W-1:0]  o_kind,
    output logic [pru_pkg::PIXEL_W-1:0] o_data,
    output logic                        o_last
);

    logic                        r_busy;
    logic                        r_rej;
    logic [SW-1:0]               r_pix;
    logic [1:0]                  r_pad;
    logic [pru_pkg::PIXEL_W-1:0] r_bgr;

    logic fire;
    logic beat_last;

    assign fire = r_busy && i_ready;

    always_comb begin
        if (r_rej) begin
            beat_last = 1'b1;
        end else if (r_pix != '0) begin
            beat_last = (r_pix == SW'(1)) && (r_pad == 2'b00);
        end else begin
            beat_last = r_pad == 2'd1;
        end
    end

    assign o_take = !r_busy || (fire && beat_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_take) begin
            r_busy <= i_job_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_rej <= i_job.rej;
            r_pix <= i_job_pix;
            r_pad <= i_job.pad;
            r_bgr <= i_job.from_mem ? i_mem_data : i_job.bgr;
        end else if (fire) begin
            if (r_pix != '0) begin
                r_pix <= r_pix - SW'(1);
            end else begin
                r_pad <= r_pad - 2'd1;
            end
        end
    end

    assign o_valid = r_busy;
    assign o_last  = beat_last;

    always_comb begin
        if (r_rej) begin
            o_kind = pru_pkg::KIND_REJECT;
            o_data = '0;
        end else if (r_pix != '0) begin
            o_kind = pru_pkg::KIND_PIXEL;
            o_data = r_bgr;
        end else begin
            o_kind = pru_pkg::KIND_PAD;
            o_data = '0;
        end
    end

`ifndef NO_ASSERTIONS
    a_busy_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rej || (r_pix != '0) || (r_pad != 2'b00)))
        else $error("emitter busy with nothing left to send");
    a_continue_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !beat_last) |=> r_busy)
        else $error("emitter dropped a job before its last word");
`endif

endmodule

FILE: rtl/pixel_replicate_upscaler_top.sv
// Integer nearest-neighbor upscaler for rows of 24-bit BGR pixels. In capture,
// each pixel word (tuser 0) is written to the line store and sent out scale
// times; the word that closes a row is followed by zero pad words so that the
// output row length in bytes is a multiple of four. When scale is above one,
// the block then replays the stored row scale-1 more times: each tick word
// (tuser 1) sends the next stored pixel scale times, again with padding at
// the end of each row. A pixel word that arrives during replay yields one
// reject word; a tick during capture is taken and yields nothing. tlast marks
// the final output word caused by an input word. The output port sends one
// word per cycle while tready is high; an input word yields scale pixel
// words, plus up to three pad words at a row end, or one reject word. A
// second input word is accepted while the first is still being sent, so the
// output runs without gaps. The line store is a single-port memory with a
// registered read port and has no clearing pass after reset. Configuration
// writes are always ready and must be made while the block is idle.
module pixel_replicate_upscaler_top #(
    parameter int MAX_WIDTH = pru_pkg::MAX_WIDTH_DEF,
    parameter int MAX_SCALE = pru_pkg::MAX_SCALE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write channel.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_index,
    input  logic [pru_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Input stream.
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [pru_pkg::PIXEL_W-1:0]    i_s_tdata,  // blue, green, red
    input  logic                           i_s_tuser,  // action
    // Output stream.
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [pru_pkg::PIXEL_W-1:0]    o_m_tdata,  // blue_out, green_out, red_out
    output logic [pru_pkg::KIND_W-1:0]     o_m_tuser,  // kind
    output logic                           o_m_tlast   // last
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int SW = $clog2(MAX_SCALE + 1);

    logic                        job_valid;
    pru_pkg::t_job               job;
    logic [SW-1:0]               job_pix;
    logic                        take;
    logic                        mem_we;
    logic                        mem_re;
    logic [AW-1:0]               mem_addr;
    logic [pru_pkg::PIXEL_W-1:0] mem_wdata;
    logic [pru_pkg::PIXEL_W-1:0] mem_rdata;

    assign o_cfg_ready = 1'b1;

    // Control stage: row and replay counters, store access and job building.
    pru_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_SCALE (MAX_SCALE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_action    (i_s_tuser),
        .i_pixel     (i_s_tdata),
        .i_take      (take),
        .o_job_valid (job_valid),
        .o_job       (job),
        .o_job_pix   (job_pix),
        .o_mem_we    (mem_we),
        .o_mem_re    (mem_re),
        .o_mem_addr  (mem_addr),
        .o_mem_wdata (mem_wdata)
    );

    // Captured row. A pixel is written in capture and read back only in a
    // later replay cycle, so reads and writes never collide.
    pru_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // Output stage: expands each job into pixel copies and pad words, or a single reject word.
    pru_emit #(
        .MAX_SCALE (MAX_SCALE)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .i_job_pix   (job_pix),
        .i_mem_data  (mem_rdata),
        .o_take      (take),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_kind      (o_m_tuser),
        .o_data      (o_m_tdata),
        .o_last      (o_m_tlast)
    );

endmodule
